### hdl/asbq_pkg.sv
// shared constants, command codes and types for the auto-stepping byte queue unit
// no dependencies; used by asbq_exec, asbq_store and auto_stepping_byte_queue_unit
package asbq_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam logic [7:0] LAST_ADDR = 8'(STORE_DEPTH - 1);
    localparam logic [15:0] DEPTH16 = 16'(STORE_DEPTH);

    // control byte bits
    localparam int CTL_AO = 0;
    localparam int CTL_DO = 1;
    localparam int CTL_DW = 2;
    localparam int CTL_ME = 3;
    localparam int CTL_QR = 7;

    localparam logic [7:0] KEEP_QR_ME = 8'h88;
    localparam logic [7:0] KEEP_QR = 8'h80;
    localparam logic [7:0] SET_DO_ME = 8'h0A;
    localparam logic [7:0] MASK_BYTE = 8'hFF;

    // command codes
    localparam logic [4:0] OP_CLR_OUT = 5'd0;
    localparam logic [4:0] OP_SET_ADDR = 5'd1;
    localparam logic [4:0] OP_ADDR_OUT = 5'd2;
    localparam logic [4:0] OP_DATA_MASKED = 5'd3;
    localparam logic [4:0] OP_WR_MASKED = 5'd4;
    localparam logic [4:0] OP_ADDR_INC = 5'd5;
    localparam logic [4:0] OP_ADDR_DEC = 5'd6;
    localparam logic [4:0] OP_DATA_OUT = 5'd7;
    localparam logic [4:0] OP_WR_PLAIN = 5'd8;
    localparam logic [4:0] OP_MASK_ON = 5'd9;
    localparam logic [4:0] OP_MASK_OFF = 5'd10;
    localparam logic [4:0] OP_DATA_KEEP = 5'd11;
    localparam logic [4:0] OP_WR_MODE = 5'd12;
    localparam logic [4:0] OP_LOAD_COUNT = 5'd13;
    localparam logic [4:0] OP_LOAD_REFILL = 5'd14;
    localparam logic [4:0] OP_START = 5'd15;
    localparam logic [4:0] OP_STOP = 5'd16;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] widx;
        logic [7:0]       wdata;
        logic [IDX_W-1:0] ridx;
    } mem_req_t;

    typedef struct packed {
        logic [7:0] addr;
        logic       ctl_ao;
        logic       ctl_do;
        logic       ctl_me;
    } status_t;

    // address modulo store depth, restoring steps on a narrow value
    function automatic logic [IDX_W-1:0] slot_of(input logic [7:0] a);
        logic [15:0] r;
        r = {8'd0, a};
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= (DEPTH16 << k))
            begin
                r = r - (DEPTH16 << k);
            end
        end
        return r[IDX_W-1:0];
    endfunction

endpackage

### hdl/auto_stepping_byte_queue_unit.sv
// Auto-stepping byte queue unit: 256-byte store with address register, output modes and a
// countdown-driven stepper. One word is accepted per clock while the result register can take a
// word; each word gives one result word through the input register, the update stage with the
// store's registered read, and the result register. The store reads as zero after reset
// through per-entry valid bits, so no clearing pass is run.
// Depends on asbq_pkg, asbq_exec and asbq_store.
module auto_stepping_byte_queue_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,      // write_mask
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,     // opcode[4:0], data_value[20:5], zero pad
    input  logic [0:0]  s_axis_tuser,     // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,     // read_value[7:0], read_mask[15:8]
    output logic [0:0]  m_axis_tuser      // read_valid
);

    logic        en;
    logic [7:0]  wm_reg;
    logic        a_valid_reg;
    logic        a_mode_reg;
    logic [4:0]  a_opcode_reg;
    logic [15:0] a_data_reg;
    logic        b_valid_reg;
    logic        c_valid_reg;
    logic        c_rv_reg;
    logic [7:0]  c_value_reg;
    logic [7:0]  c_mask_reg;
    logic [7:0]  cur_byte;

    asbq_pkg::mem_req_t req;
    asbq_pkg::status_t  st;

    // whole pipe moves together whenever the result register can take a word
    assign en = !c_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm_reg <= asbq_pkg::MASK_BYTE;
        end
        else if (cfg_wr_en)
        begin
            wm_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_axis_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mode_reg <= s_axis_tuser[0];
            a_opcode_reg <= s_axis_tdata[4:0];
            a_data_reg <= s_axis_tdata[20:5];
            if (st.ctl_ao)
            begin
                c_rv_reg <= 1'b1;
                c_value_reg <= st.addr;
                c_mask_reg <= asbq_pkg::MASK_BYTE;
            end
            else if (st.ctl_do)
            begin
                c_rv_reg <= 1'b1;
                c_value_reg <= cur_byte;
                c_mask_reg <= st.ctl_me ? wm_reg : asbq_pkg::MASK_BYTE;
            end
            else
            begin
                c_rv_reg <= 1'b0;
                c_value_reg <= 8'd0;
                c_mask_reg <= 8'd0;
            end
        end
    end

    asbq_exec u_exec
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (en && a_valid_reg),
        .mode       (a_mode_reg),
        .opcode     (a_opcode_reg),
        .data_value (a_data_reg),
        .cur_byte   (cur_byte),
        .write_mask (wm_reg),
        .req        (req),
        .st         (st)
    );

    asbq_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .req      (req),
        .cur_byte (cur_byte)
    );

    assign m_axis_tvalid = c_valid_reg;
    assign m_axis_tdata = {c_mask_reg, c_value_reg};
    assign m_axis_tuser = c_rv_reg;

    // an idle result carries all-zero data
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("idle result with nonzero data");

    // a mask other than all ones can only be the configured write mask
    a_mask_src: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[15:8] != 8'hFF
        |-> m_axis_tdata[15:8] == wm_reg)
        else $error("result mask not from write mask");

    // an accepted word enters the input register
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> a_valid_reg)
        else $error("accepted word lost");

    // a stalled pipe leaves the state untouched
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(st.addr) && $stable(st.ctl_ao) && $stable(st.ctl_do))
        else $error("state changed while stalled");

    // no store write happens without a pipeline advance
    a_write_en: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |-> en && a_valid_reg)
        else $error("store write outside an item step");

endmodule

### hdl/asbq_store.sv
// byte store with one write and one registered read port, per-entry valid bits
// depends on asbq_pkg
module asbq_store
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  asbq_pkg::mem_req_t req,
    output logic [7:0]        cur_byte
);

    logic [7:0] mem [asbq_pkg::STORE_DEPTH];
    logic [7:0] rd_reg;
    logic [7:0] wdata_reg;
    logic [asbq_pkg::STORE_DEPTH-1:0] vld_reg;
    logic       hit_reg;
    logic       rvld_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.widx] <= req.wdata;
        end
        if (en)
        begin
            rd_reg <= mem[req.ridx];
            wdata_reg <= req.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                vld_reg[req.widx] <= 1'b1;
            end
            if (en)
            begin
                hit_reg <= req.we && (req.widx == req.ridx);
                rvld_reg <= vld_reg[req.ridx];
            end
        end
    end

    // byte at the current address; never-written entries read as zero
    assign cur_byte = hit_reg ? wdata_reg : (rvld_reg ? rd_reg : 8'd0);

endmodule

### hdl/asbq_exec.sv
// command and stepper logic: address, control, countdown and refill registers
// depends on asbq_pkg
module asbq_exec
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               mode,
    input  logic [4:0]         opcode,
    input  logic [15:0]        data_value,
    input  logic [7:0]         cur_byte,
    input  logic [7:0]         write_mask,
    output asbq_pkg::mem_req_t req,
    output asbq_pkg::status_t  st
);

    logic [7:0]  address_reg, address_next;
    logic [7:0]  control_reg, control_next;
    logic [15:0] countdown_reg, countdown_next;
    logic [15:0] refill_reg, refill_next;
    logic [7:0]  lo;
    logic [7:0]  masked;
    logic        we;
    logic [7:0]  wdata;

    assign lo = data_value[7:0];
    assign masked = (cur_byte & ~write_mask) | (lo & write_mask);

    always_comb
    begin
        address_next = address_reg;
        control_next = control_reg;
        countdown_next = countdown_reg;
        refill_next = refill_reg;
        we = 1'b0;
        wdata = masked;
        if (step)
        begin
            if (!mode)
            begin
                case (opcode)
                    asbq_pkg::OP_CLR_OUT:
                        control_next = control_reg & asbq_pkg::KEEP_QR_ME;
                    asbq_pkg::OP_SET_ADDR:
                        address_next = lo;
                    asbq_pkg::OP_ADDR_OUT:
                    begin
                        control_next = control_reg & asbq_pkg::KEEP_QR_ME;
                        control_next[asbq_pkg::CTL_AO] = 1'b1;
                    end
                    asbq_pkg::OP_DATA_MASKED:
                        control_next = (control_reg & asbq_pkg::KEEP_QR)
                                       | asbq_pkg::SET_DO_ME;
                    asbq_pkg::OP_WR_MASKED:
                        we = 1'b1;
                    asbq_pkg::OP_ADDR_INC:
                        address_next = address_reg + 8'd1;
                    asbq_pkg::OP_ADDR_DEC:
                        address_next = address_reg - 8'd1;
                    asbq_pkg::OP_DATA_OUT:
                    begin
                        control_next = control_reg & asbq_pkg::KEEP_QR;
                        control_next[asbq_pkg::CTL_DO] = 1'b1;
                    end
                    asbq_pkg::OP_WR_PLAIN:
                    begin
                        we = 1'b1;
                        wdata = lo;
                    end
                    asbq_pkg::OP_MASK_ON:
                        control_next[asbq_pkg::CTL_ME] = 1'b1;
                    asbq_pkg::OP_MASK_OFF:
                        control_next[asbq_pkg::CTL_ME] = 1'b0;
                    asbq_pkg::OP_DATA_KEEP:
                    begin
                        control_next = control_reg & asbq_pkg::KEEP_QR_ME;
                        control_next[asbq_pkg::CTL_DO] = 1'b1;
                    end
                    asbq_pkg::OP_WR_MODE:
                    begin
                        control_next = control_reg & asbq_pkg::KEEP_QR_ME;
                        control_next[asbq_pkg::CTL_DW] = 1'b1;
                    end
                    asbq_pkg::OP_LOAD_COUNT:
                        countdown_next = data_value;
                    asbq_pkg::OP_LOAD_REFILL:
                        refill_next = data_value;
                    asbq_pkg::OP_START:
                        control_next[asbq_pkg::CTL_QR] = 1'b1;
                    asbq_pkg::OP_STOP:
                        control_next[asbq_pkg::CTL_QR] = 1'b0;
                    default:
                        control_next = control_reg;
                endcase
            end
            else if (control_reg[asbq_pkg::CTL_QR])
            begin
                if (countdown_reg != 16'd0)
                begin
                    countdown_next = countdown_reg - 16'd1;
                end
                else
                begin
                    we = control_reg[asbq_pkg::CTL_DW];
                    // stepper halts at the last address instead of wrapping
                    if (address_reg < asbq_pkg::LAST_ADDR)
                    begin
                        address_next = address_reg + 8'd1;
                    end
                    else
                    begin
                        control_next[asbq_pkg::CTL_QR] = 1'b0;
                    end
                    countdown_next = refill_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg <= 8'd0;
            control_reg <= 8'd0;
            countdown_reg <= 16'd0;
            refill_reg <= 16'd0;
        end
        else
        begin
            address_reg <= address_next;
            control_reg <= control_next;
            countdown_reg <= countdown_next;
            refill_reg <= refill_next;
        end
    end

    // writes go to the old address, the read fetches the byte at the new one
    assign req.we = we;
    assign req.widx = asbq_pkg::slot_of(address_reg);
    assign req.wdata = wdata;
    assign req.ridx = asbq_pkg::slot_of(address_next);

    assign st.addr = address_reg;
    assign st.ctl_ao = control_reg[asbq_pkg::CTL_AO];
    assign st.ctl_do = control_reg[asbq_pkg::CTL_DO];
    assign st.ctl_me = control_reg[asbq_pkg::CTL_ME];

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// testbench for auto_stepping_byte_queue_unit: command and tick words on the input stream,
// read words checked against an in-bench predictor of store, address, control and stepper
// depends on asbq_pkg and the unit's RTL
module testbench;
    import asbq_pkg::*;

    localparam logic MODE_CMD = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int WORDS_PER_PHASE = 160;
    localparam int LONG_HOLD = 260;

    typedef struct packed {
        logic       rd_valid;
        logic [7:0] rd_value;
        logic [7:0] rd_mask;
    } read_word_t;

    class byte_queue_scoreboard;
        bit [7:0]   mem [STORE_DEPTH];
        bit [7:0]   addr;
        bit [7:0]   ctl;
        bit [15:0]  count;
        bit [15:0]  reload;
        bit [7:0]   wmask;
        read_word_t pending_reads[$];
        int         errors;
        int         checked;
        int         ticks;
        int         commands;
        int         step_actions;
        int         end_stops;

        function new();
            foreach (mem[i])
                mem[i] = 8'h00;
            addr = 8'h00;
            ctl = 8'h00;
            count = 16'h0000;
            reload = 16'h0000;
            wmask = MASK_BYTE;
        endfunction

        function void set_mask(input bit [7:0] v);
            wmask = v;
        endfunction

        function void store_masked(input bit [7:0] d);
            int i;
            i = int'(addr) % STORE_DEPTH;
            mem[i] = (mem[i] & ~wmask) | (d & wmask);
        endfunction

        function void note_word(input bit mode, input bit [4:0] op, input bit [15:0] d);
            read_word_t r;
            if (mode == MODE_CMD)
            begin
                commands++;
                case (op)
                    OP_CLR_OUT: ctl &= KEEP_QR_ME;
                    OP_SET_ADDR: addr = d[7:0];
                    OP_ADDR_OUT:
                    begin
                        ctl &= KEEP_QR_ME;
                        ctl[CTL_AO] = 1'b1;
                    end
                    OP_DATA_MASKED:
                    begin
                        ctl &= KEEP_QR;
                        ctl |= SET_DO_ME;
                    end
                    OP_WR_MASKED: store_masked(d[7:0]);
                    OP_ADDR_INC: addr = addr + 8'd1;
                    OP_ADDR_DEC: addr = addr - 8'd1;
                    OP_DATA_OUT:
                    begin
                        ctl &= KEEP_QR;
                        ctl[CTL_DO] = 1'b1;
                    end
                    OP_WR_PLAIN: mem[int'(addr) % STORE_DEPTH] = d[7:0];
                    OP_MASK_ON: ctl[CTL_ME] = 1'b1;
                    OP_MASK_OFF: ctl[CTL_ME] = 1'b0;
                    OP_DATA_KEEP:
                    begin
                        ctl &= KEEP_QR_ME;
                        ctl[CTL_DO] = 1'b1;
                    end
                    OP_WR_MODE:
                    begin
                        ctl &= KEEP_QR_ME;
                        ctl[CTL_DW] = 1'b1;
                    end
                    OP_LOAD_COUNT: count = d;
                    OP_LOAD_REFILL: reload = d;
                    OP_START: ctl[CTL_QR] = 1'b1;
                    OP_STOP: ctl[CTL_QR] = 1'b0;
                    default: ;
                endcase
            end
            else
            begin
                ticks++;
                if (ctl[CTL_QR])
                begin
                    if (count != 16'd0)
                        count = count - 16'd1;
                    else
                    begin
                        step_actions++;
                        if (ctl[CTL_DW])
                            store_masked(d[7:0]);
                        if (int'(addr) < STORE_DEPTH - 1)
                            addr = addr + 8'd1;
                        else
                        begin
                            ctl[CTL_QR] = 1'b0;
                            end_stops++;
                        end
                        count = reload;
                    end
                end
            end

            if (ctl[CTL_AO])
                r = '{1'b1, addr, MASK_BYTE};
            else if (ctl[CTL_DO])
                r = '{1'b1, mem[int'(addr) % STORE_DEPTH], ctl[CTL_ME] ? wmask : MASK_BYTE};
            else
                r = '{1'b0, 8'h00, 8'h00};
            pending_reads.push_back(r);
        endfunction

        function void check_word(input logic v, input logic [7:0] val, input logic [7:0] m);
            read_word_t e;
            if (pending_reads.size() == 0)
            begin
                $error("read word with nothing expected: valid %0d value %0d mask %0d",
                       v, val, m);
                errors++;
                return;
            end
            e = pending_reads.pop_front();
            checked++;
            if (v !== e.rd_valid)
            begin
                $error("read_valid: expected %0d, got %0d", e.rd_valid, v);
                errors++;
            end
            if (val !== e.rd_value)
            begin
                $error("read_value: expected %0d, got %0d", e.rd_value, val);
                errors++;
            end
            if (m !== e.rd_mask)
            begin
                $error("read_mask: expected %0d, got %0d", e.rd_mask, m);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    byte_queue_scoreboard sb = new();
    int  cycle_count = 0;
    int  sent_words = 0;
    int  mask_settings = 1;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;

    auto_stepping_byte_queue_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // read side: random stalls plus the long hold-off when asked for
    initial
    begin : read_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[15:8]);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                m_axis_tready <= (stall_left == 0);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic mode, input logic [4:0] op, input logic [15:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, d, op};
        s_axis_tuser <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_word(mode, op, d);
        sent_words++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_reads.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_mask_reg(input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_mask(v);
        mask_settings++;
    endtask

    // well-formed stepper run: place address, pick output and write mode, arm, then tick
    task automatic stepper_run();
        logic [7:0] a;
        logic [4:0] out_ops [6];
        int n;
        out_ops = '{OP_WR_MODE, OP_DATA_KEEP, OP_ADDR_OUT, OP_DATA_MASKED, OP_DATA_OUT,
                    OP_CLR_OUT};
        a = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(240, 255)) : 8'($urandom);
        send_word(MODE_CMD, OP_SET_ADDR, {8'($urandom), a});
        send_word(MODE_CMD, out_ops[$urandom_range(0, 5)], 16'($urandom));
        if ($urandom_range(0, 2) == 0)
            send_word(MODE_CMD, $urandom_range(0, 1) ? OP_MASK_ON : OP_MASK_OFF,
                      16'($urandom));
        if ($urandom_range(0, 1) == 0)
            send_word(MODE_CMD, OP_WR_MODE, 16'($urandom));
        send_word(MODE_CMD, OP_LOAD_REFILL, 16'($urandom_range(0, 2)));
        send_word(MODE_CMD, OP_LOAD_COUNT, 16'($urandom_range(0, 3)));
        send_word(MODE_CMD, OP_START, 16'($urandom));
        n = $urandom_range(4, 24);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(MODE_CMD, $urandom_range(0, 1) ? OP_DATA_KEEP : OP_ADDR_OUT,
                          16'($urandom));
            else
                send_word(MODE_TICK, 5'($urandom), 16'($urandom));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            send_word(MODE_CMD, OP_STOP, 16'($urandom));
            send_word(MODE_TICK, 5'($urandom), 16'($urandom));
        end
    endtask

    task automatic noise_words(input int n);
        repeat (n)
        begin
            send_word(1'($urandom), 5'($urandom), 16'($urandom));
        end
    endtask

    task automatic random_phase(input int quota);
        int stop_at;
        stop_at = sent_words + quota;
        while (sent_words < stop_at)
        begin
            if ($urandom_range(0, 3) != 0)
                stepper_run();
            else
                noise_words($urandom_range(1, 6));
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] masks [5];
        masks = '{8'h00, 8'hA5, 8'hFF, 8'($urandom), 8'h3C};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, wraps, every command, unused codes, last-address stop
        send_word(MODE_TICK, 5'd31, 16'hFFFF);
        send_word(MODE_CMD, OP_ADDR_OUT, 16'h0000);
        send_word(MODE_CMD, OP_ADDR_DEC, 16'h0000);
        send_word(MODE_CMD, OP_ADDR_INC, 16'hFFFF);
        send_word(MODE_CMD, OP_SET_ADDR, 16'hFFFF);
        send_word(MODE_CMD, OP_WR_PLAIN, 16'h00C3);
        send_word(MODE_CMD, OP_DATA_OUT, 16'h0000);
        send_word(MODE_CMD, OP_MASK_ON, 16'h0000);
        send_word(MODE_CMD, OP_DATA_MASKED, 16'h0000);
        send_word(MODE_CMD, OP_WR_MASKED, 16'hFF00);
        send_word(MODE_CMD, OP_MASK_OFF, 16'h0000);
        send_word(MODE_CMD, OP_DATA_KEEP, 16'h0000);
        send_word(MODE_CMD, 5'd17, 16'hFFFF);
        send_word(MODE_CMD, 5'd31, 16'hFFFF);
        send_word(MODE_CMD, OP_CLR_OUT, 16'h0000);
        send_word(MODE_CMD, OP_LOAD_REFILL, 16'h0001);
        send_word(MODE_CMD, OP_LOAD_COUNT, 16'h0001);
        send_word(MODE_CMD, OP_WR_MODE, 16'h0000);
        send_word(MODE_CMD, OP_START, 16'h0000);
        send_word(MODE_TICK, 5'd0, 16'h0011);
        send_word(MODE_TICK, 5'd0, 16'h00EE);
        send_word(MODE_TICK, 5'd0, 16'h0055);
        send_word(MODE_CMD, OP_DATA_KEEP, 16'h0000);
        send_word(MODE_CMD, OP_LOAD_COUNT, 16'hFFFF);
        send_word(MODE_CMD, OP_STOP, 16'h0000);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            write_mask_reg(masks[p]);
            if (p == 1)
            begin
                // fill the pipe against a stalled read side
                no_idle = 1'b1;
                hold_req = 1'b1;
                noise_words(40);
                no_idle = 1'b0;
            end
            if (p == 3)
            begin
                no_idle = 1'b1;
                random_phase(60);
                no_idle = 1'b0;
            end
            random_phase(WORDS_PER_PHASE);
            drain();
        end

        $display("%0d words (%0d commands, %0d ticks), %0d reads checked, %0d mask settings",
                 sent_words, sb.commands, sb.ticks, sb.checked, mask_settings);
        $display("%0d stepper actions, %0d stops at the last address",
                 sb.step_actions, sb.end_stops);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
